@@ rtl/image_packet_deframer_crc32_defines.svh @@
// ----------------------------------------------------------------------------
// Image packet deframer assertion macros
// Clocked property wrappers shared by the deframer modules
// ----------------------------------------------------------------------------
`ifndef IMAGE_PACKET_DEFRAMER_CRC32_DEFINES_SVH
`define IMAGE_PACKET_DEFRAMER_CRC32_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define IPDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define IPDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IPDF_ASSERT(label, prop, msg)
`define IPDF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/ipdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Image packet deframer package
// Header layout, codes, result item type and the CRC-32 byte update
// ----------------------------------------------------------------------------
package ipdf_pkg;

  localparam int unsigned HEADER_BYTES = 40;
  localparam int unsigned HDR_BITS     = HEADER_BYTES * 8;

  // byte offsets inside the little-endian header
  localparam int unsigned OFF_MAGIC    = 0;
  localparam int unsigned OFF_VERSION  = 4;
  localparam int unsigned OFF_HLEN     = 6;
  localparam int unsigned OFF_SIZE     = 8;
  localparam int unsigned OFF_WIDTH    = 12;
  localparam int unsigned OFF_HEIGHT   = 16;
  localparam int unsigned OFF_SEQ      = 20;
  localparam int unsigned OFF_TSTAMP   = 28;
  localparam int unsigned OFF_CHECKSUM = 36;

  localparam logic [31:0] MAGIC_VALUE = 32'h3247_4D49;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES32  = 32'hFFFF_FFFF;

  localparam logic [15:0] EXPECTED_VERSION_RST = 16'd1;
  localparam logic [13:0] MAX_DIMENSION_RST    = 14'd8192;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;

  // configuration register indexes
  localparam logic [0:0] CFG_EXPECTED_VERSION = 1'b0;
  localparam logic [0:0] CFG_MAX_DIMENSION    = 1'b1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TRUNCATED = 2'd1,
    STATUS_HDR_BAD   = 2'd2,
    STATUS_CRC_FAIL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] expected_version;
    logic [13:0] max_dimension;
  } cfg_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  pixel_value;
    status_e     status_code;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [63:0] frame_sequence;
    logic [63:0] frame_timestamp;
  } item_t;

  // results of one byte: optional pixel, then optional status
  typedef struct packed {
    logic  pix_valid;
    logic  stat_valid;
    item_t pix;
    item_t stat;
  } results_t;

  // reflected crc-32, one byte folded in
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/ipdf_parser.sv @@
// ----------------------------------------------------------------------------
// Image packet deframer parser
// Header capture and check, payload crc, pixel items and end-of-packet status
// ----------------------------------------------------------------------------
`include "image_packet_deframer_crc32_defines.svh"

module ipdf_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_packet_i,
  input  ipdf_pkg::cfg_t      cfg_i,
  output ipdf_pkg::results_t  res_o
);

  logic [31:0]                  cnt_q, cnt_d;
  logic [31:0]                  crc_q, crc_d;
  logic                         hv_q, hv_d;
  logic [27:0]                  prod_q, prod_d;
  logic [ipdf_pkg::HDR_BITS-1:0] hdr_q, hdr_d;

  logic [31:0] cnt_inc;
  logic [31:0] crc_next;
  logic        in_hdr;
  logic        hdr_last;
  logic        hdr_ok;
  logic        pix;
  logic [31:0] s_width, s_height;
  logic [31:0] payload_len;
  logic        size_bad;
  ipdf_pkg::status_e status;

  // header dimensions as seen with the current byte shifted in
  assign s_width  = hdr_d[ipdf_pkg::OFF_WIDTH*8 +: 32];
  assign s_height = hdr_d[ipdf_pkg::OFF_HEIGHT*8 +: 32];

  always_comb begin
    cnt_inc  = (cnt_q == ipdf_pkg::ALL_ONES32) ? cnt_q : cnt_q + 32'd1;
    in_hdr   = cnt_q < 32'(ipdf_pkg::HEADER_BYTES);
    hdr_last = cnt_q == 32'(ipdf_pkg::HEADER_BYTES - 1);
    hdr_d    = in_hdr ? {data_byte_i, hdr_q[ipdf_pkg::HDR_BITS-1:8]} : hdr_q;

    hdr_ok = (hdr_d[ipdf_pkg::OFF_MAGIC*8 +: 32] == ipdf_pkg::MAGIC_VALUE)
          && (hdr_d[ipdf_pkg::OFF_VERSION*8 +: 16] == cfg_i.expected_version)
          && (hdr_d[ipdf_pkg::OFF_HLEN*8 +: 16] == 16'(ipdf_pkg::HEADER_BYTES))
          && (s_width != 32'd0) && (s_width <= {18'd0, cfg_i.max_dimension})
          && (s_height != 32'd0) && (s_height <= {18'd0, cfg_i.max_dimension});

    hv_d     = hv_q;
    prod_d   = prod_q;
    if (in_hdr && hdr_last) begin
      hv_d   = hdr_ok;
      // dimensions fit 14 bits whenever the header passes
      prod_d = 28'(s_width[13:0] * s_height[13:0]);
    end

    pix      = !in_hdr && hv_q;
    crc_next = pix ? ipdf_pkg::crc32_byte(crc_q, data_byte_i) : crc_q;

    // a header finishing on the final byte leaves an empty payload, never w*h
    payload_len = cnt_inc - 32'(ipdf_pkg::HEADER_BYTES);
    size_bad    = hdr_last || ({4'd0, prod_q} != payload_len)
               || (hdr_q[ipdf_pkg::OFF_SIZE*8 +: 32] != cnt_inc);

    if (cnt_inc < 32'(ipdf_pkg::HEADER_BYTES)) begin
      status = ipdf_pkg::STATUS_TRUNCATED;
    end else if (!hv_d || size_bad) begin
      status = ipdf_pkg::STATUS_HDR_BAD;
    end else if ((crc_next ^ ipdf_pkg::ALL_ONES32) !=
                 hdr_q[ipdf_pkg::OFF_CHECKSUM*8 +: 32]) begin
      status = ipdf_pkg::STATUS_CRC_FAIL;
    end else begin
      status = ipdf_pkg::STATUS_OK;
    end

    cnt_d = cnt_inc;
    crc_d = crc_next;
    if (end_of_packet_i) begin
      cnt_d = 32'd0;
      crc_d = ipdf_pkg::ALL_ONES32;
      hv_d  = 1'b0;
    end

    res_o                      = '0;
    res_o.pix_valid            = step_i && pix;
    res_o.stat_valid           = step_i && end_of_packet_i;
    res_o.pix.item_kind        = ipdf_pkg::KIND_PIXEL;
    res_o.pix.pixel_value      = data_byte_i;
    res_o.pix.status_code      = ipdf_pkg::STATUS_OK;
    res_o.stat.item_kind       = ipdf_pkg::KIND_STATUS;
    res_o.stat.status_code     = status;
    if (status == ipdf_pkg::STATUS_OK) begin
      res_o.stat.frame_width     = hdr_q[ipdf_pkg::OFF_WIDTH*8 +: 14];
      res_o.stat.frame_height    = hdr_q[ipdf_pkg::OFF_HEIGHT*8 +: 14];
      res_o.stat.frame_sequence  = hdr_q[ipdf_pkg::OFF_SEQ*8 +: 64];
      res_o.stat.frame_timestamp = hdr_q[ipdf_pkg::OFF_TSTAMP*8 +: 64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= ipdf_pkg::ALL_ONES32;
      hv_q  <= 1'b0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
      hv_q  <= hv_d;
    end
  end

  // header bytes and product are only read once the header is complete
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hdr_q  <= hdr_d;
      prod_q <= prod_d;
    end
  end

  `IPDF_ASSERT_ALWAYS(a_hv_implies_count,
    hv_q |-> (cnt_q >= 32'(ipdf_pkg::HEADER_BYTES)), "header valid before header complete")
  `IPDF_ASSERT(a_pix_needs_header,
    res_o.pix_valid |-> hv_q, "pixel emitted without valid header")
  `IPDF_ASSERT(a_status_clears,
    res_o.stat_valid |=> (cnt_q == 32'd0 && !hv_q), "packet state not cleared after status")

endmodule

@@ rtl/ipdf_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Image packet deframer result queue
// Takes up to two result items per cycle, hands out one per transaction
// ----------------------------------------------------------------------------
`include "image_packet_deframer_crc32_defines.svh"

module ipdf_out_fifo #(
  parameter int unsigned DEPTH = ipdf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipdf_pkg::results_t res_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ipdf_pkg::item_t    head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ipdf_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   rd_q, rd_d, wr_q, wr_d, wr_nxt;
  logic [CW-1:0]   count_q, count_d;
  logic [1:0]      push_n;
  logic            pop;
  ipdf_pkg::item_t first;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    push_n  = {1'b0, res_i.pix_valid} + {1'b0, res_i.stat_valid};
    pop     = (count_q != '0) && !out_stall_i;
    first   = res_i.pix_valid ? res_i.pix : res_i.stat;
    wr_nxt  = ptr_inc(wr_q);
    wr_d    = (push_n == 2'd2) ? ptr_inc(wr_nxt) : ((push_n == 2'd1) ? wr_nxt : wr_q);
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CW'(push_n) - CW'(pop);
  end

  // room for two more items, judged on registered state only
  assign space_o     = count_q <= CW'(DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign head_o      = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= '0;
      wr_q    <= '0;
      count_q <= '0;
    end else begin
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_nxt] <= res_i.stat;
    end
  end

  `IPDF_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue count above depth")
  `IPDF_ASSERT(a_push_fits,
    (push_n != 2'd0) |-> (({1'b0, count_q} + (CW+1)'(push_n)) <= (CW+1)'(DEPTH)),
    "push into full queue")
  `IPDF_ASSERT(a_pop_dec,
    (pop && push_n == 2'd0) |=> (count_q == $past(count_q) - CW'(1)),
    "queue count did not drop on pop")

endmodule

@@ rtl/image_packet_deframer_crc32.sv @@
// ----------------------------------------------------------------------------
// Image packet deframer with CRC-32 payload check
// Parses a byte stream of framed image packets into pixel and status items
// ----------------------------------------------------------------------------
// usage:
//   input channel: one packet byte per transaction, end_of_packet on the last
//   byte. the first 40 bytes form the header; with a good header every later
//   byte comes out as a pixel item and is folded into a reflected crc-32.
//   the last byte of a packet also yields one status item (ok, truncated,
//   header invalid, checksum failed); header fields are filled when ok.
//   output channel: one result item per transaction, in packet order.
//   config port: write enable, register index and data; write only while
//   the block holds no transaction in flight.
// path: an accepted byte sits in the input register, then the parser writes
//   its results into the result queue, from which they are offered.
// throughput: one byte per cycle. a final byte that also carries a pixel
//   gives two results, so the output side needs an extra transaction then; the
//   result queue of FIFO_DEPTH entries absorbs this and input stalls only
//   when the queue lacks room for two items.
// reset: config returns to version 1 and max dimension 8192, packet state
//   and queue are cleared, no result is offered.
// receiver stall: the head item holds; once the queue lacks room for two items,
//   in_stall_o rises and the input byte waits in the input register.
// ----------------------------------------------------------------------------
module image_packet_deframer_crc32 #(
  parameter int unsigned FIFO_DEPTH = ipdf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  input  logic        in_end_of_packet_i,

  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_item_kind_o,
  output logic [7:0]  out_pixel_value_o,
  output logic [1:0]  out_status_code_o,
  output logic [13:0] out_frame_width_o,
  output logic [13:0] out_frame_height_o,
  output logic [63:0] out_frame_sequence_o,
  output logic [63:0] out_frame_timestamp_o,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  ipdf_pkg::cfg_t     cfg_q;
  ipdf_pkg::results_t res;
  ipdf_pkg::item_t    head;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       space;
  logic       advance;
  logic       in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= ipdf_pkg::EXPECTED_VERSION_RST;
      cfg_q.max_dimension    <= ipdf_pkg::MAX_DIMENSION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ipdf_pkg::CFG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_wdata_i;
        ipdf_pkg::CFG_MAX_DIMENSION:    cfg_q.max_dimension    <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // the held byte moves on once the queue has room for both possible results
  assign advance    = s1_valid_q && space;
  assign in_stall_o = s1_valid_q && !space;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_data_byte_i;
      s1_last_q <= in_end_of_packet_i;
    end
  end

  ipdf_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .data_byte_i     (s1_byte_q),
    .end_of_packet_i (s1_last_q),
    .cfg_i           (cfg_q),
    .res_o           (res)
  );

  ipdf_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_item_kind_o       = head.item_kind;
  assign out_pixel_value_o     = head.pixel_value;
  assign out_status_code_o     = head.status_code;
  assign out_frame_width_o     = head.frame_width;
  assign out_frame_height_o    = head.frame_height;
  assign out_frame_sequence_o  = head.frame_sequence;
  assign out_frame_timestamp_o = head.frame_timestamp;

endmodule
